// File: src/pfb_pkg.sv
package pfb_pkg;

  // geometry
  localparam int BRANCHES = 1024;
  localparam int TAPS     = 16;

  // word field widths
  localparam int BRANCH_W    = 10;
  localparam int TAP_FIELD_W = 4;
  localparam int COEF_W      = 18;
  localparam int SAMPLE_W    = 24;
  localparam int OUT_W       = 46;

  localparam int ADDR_W = $clog2(BRANCHES);
  localparam int TAP_W  = $clog2(TAPS);
  localparam int FRM_W  = $clog2(TAPS);

  // adder tree: groups of four products, then one final add
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int GROUP     = 4;
  localparam int GROUPS    = (TAPS + GROUP - 1) / GROUP;
  localparam int GRP_W     = PROD_W + $clog2(GROUP);
  localparam int SUM_RAW_W = GRP_W + $clog2(GROUPS) + 1;
  localparam int SUM_W     = (SUM_RAW_W > OUT_W) ? SUM_RAW_W : OUT_W;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef sample_t [TAPS-1:0]         dly_row_t;
  typedef coef_t   [TAPS-1:0]         coef_row_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    dly_row_t          data;
  } dly_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [TAP_W-1:0]  lane;
    coef_t             data;
  } coef_wr_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic [BRANCH_W-1:0]     branch;
  } res_t;

endpackage

// File: src/pfb_if.sv
interface pfb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic [pfb_pkg::BRANCH_W-1:0]         branch;
  logic [pfb_pkg::TAP_FIELD_W-1:0]      tap;
  logic signed [pfb_pkg::COEF_W-1:0]    coefficient;
  logic signed [pfb_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, kind, branch, tap, coefficient, sample, input ready);
  modport sink   (input valid, kind, branch, tap, coefficient, sample, output ready);
endinterface

interface pfb_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pfb_pkg::OUT_W-1:0]  filtered;
  logic [pfb_pkg::BRANCH_W-1:0]      out_branch;

  modport source (output valid, filtered, out_branch, input ready);
  modport sink   (input valid, filtered, out_branch, output ready);
endinterface

// File: src/pfb_delay_mem.sv
module pfb_delay_mem (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [pfb_pkg::ADDR_W-1:0]     rd_addr,
  output pfb_pkg::dly_row_t              rd_data,
  input  pfb_pkg::dly_wr_t               wr,
  output logic                           busy
);

  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN   = 1'b1;

  pfb_pkg::dly_row_t mem [pfb_pkg::BRANCHES];

  logic                       state_r;
  logic [pfb_pkg::ADDR_W-1:0] clr_addr_r;

  // one row zeroed per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          if (clr_addr_r == pfb_pkg::ADDR_W'(pfb_pkg::BRANCHES - 1)) begin
            state_r <= ST_RUN;
          end
          clr_addr_r <= clr_addr_r + 1'b1;
        end
        ST_RUN: begin
          state_r <= ST_RUN;
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      mem[clr_addr_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  assign busy = (state_r == ST_CLEAR);

endmodule

// File: src/pfb_coef_mem.sv
module pfb_coef_mem (
  input  logic                       clk,
  input  logic [pfb_pkg::ADDR_W-1:0] rd_addr,
  output pfb_pkg::coef_row_t         rd_data,
  input  pfb_pkg::coef_wr_t          wr
);

  pfb_pkg::coef_row_t mem [pfb_pkg::BRANCHES];

  // per-tap lane write, whole row read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr][wr.lane] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/pfb_mac.sv
module pfb_mac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  pfb_pkg::dly_row_t            row,
  input  pfb_pkg::coef_row_t           coef,
  input  logic [pfb_pkg::BRANCH_W-1:0] branch,
  output logic                         res_valid,
  output pfb_pkg::res_t                res
);

  localparam logic signed [pfb_pkg::SUM_W-1:0] SAT_MAX =
    {{(pfb_pkg::SUM_W - pfb_pkg::OUT_W + 1){1'b0}}, {(pfb_pkg::OUT_W - 1){1'b1}}};
  localparam logic signed [pfb_pkg::SUM_W-1:0] SAT_MIN =
    {{(pfb_pkg::SUM_W - pfb_pkg::OUT_W + 1){1'b1}}, {(pfb_pkg::OUT_W - 1){1'b0}}};

  logic signed [pfb_pkg::PROD_W-1:0] p_r   [pfb_pkg::TAPS];
  logic signed [pfb_pkg::PROD_W-1:0] p_nxt [pfb_pkg::TAPS];
  logic signed [pfb_pkg::GRP_W-1:0]  g_r   [pfb_pkg::GROUPS];
  logic signed [pfb_pkg::GRP_W-1:0]  g_nxt [pfb_pkg::GROUPS];
  logic                              p_valid_r, g_valid_r;
  logic [pfb_pkg::BRANCH_W-1:0]      p_branch_r, g_branch_r;
  logic signed [pfb_pkg::SUM_W-1:0]  sum;

  // one multiplier per tap lane
  always_comb begin
    for (int k = 0; k < pfb_pkg::TAPS; k++) begin
      p_nxt[k] = pfb_pkg::PROD_W'($signed(row[k]) * $signed(coef[k]));
    end
  end

  always_comb begin
    int idx;
    for (int g = 0; g < pfb_pkg::GROUPS; g++) begin
      g_nxt[g] = '0;
      for (int j = 0; j < pfb_pkg::GROUP; j++) begin
        idx = g * pfb_pkg::GROUP + j;
        if (idx < pfb_pkg::TAPS) begin
          g_nxt[g] = g_nxt[g] + pfb_pkg::GRP_W'(p_r[idx]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      g_valid_r <= 1'b0;
    end else begin
      p_valid_r <= in_valid;
      g_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    g_r        <= g_nxt;
    p_branch_r <= branch;
    g_branch_r <= p_branch_r;
  end

  always_comb begin
    sum = '0;
    for (int g = 0; g < pfb_pkg::GROUPS; g++) begin
      sum = sum + pfb_pkg::SUM_W'(g_r[g]);
    end
  end

  // clamp to the output range; only reachable with long filters
  always_comb begin
    priority if (sum > SAT_MAX) begin
      res.filtered = SAT_MAX[pfb_pkg::OUT_W-1:0];
    end else if (sum < SAT_MIN) begin
      res.filtered = SAT_MIN[pfb_pkg::OUT_W-1:0];
    end else begin
      res.filtered = sum[pfb_pkg::OUT_W-1:0];
    end
    res.branch = g_branch_r;
  end

  assign res_valid = g_valid_r;

endmodule

// File: src/pfb_out_fifo.sv
module pfb_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pfb_pkg::res_t push_data,
  input  logic          pop,
  output logic          valid,
  output pfb_pkg::res_t data
);

  pfb_pkg::res_t               slot_r [pfb_pkg::FIFO_DEPTH];
  logic [pfb_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [pfb_pkg::CNT_W-1:0]   count_r;

  // never overfilled: upstream holds credit for every word in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign valid = (count_r != '0);
  assign data  = slot_r[rd_ptr_r];

endmodule

// File: src/polyphase_fir_branch_synthesis_top.sv
// Polyphase filterbank FIR stage, one 16-tap delay line per branch.
//
// in_ch  : words of kind 0 load one coefficient at (branch, tap); words of
//          kind 1 bring one sample for a branch. Valid/ready handshake.
// out_ch : one result word (filtered, out_branch) per sample once TAPS-1
//          frames have completed; a frame ends at the sample for the last
//          branch. Loads and warm-up samples give no word.
// Throughput: one input word per cycle while in_ch.ready is high. Each branch
//   row of the delay and coefficient memories is read whole, and the delay
//   row is written back in the next cycle, so words for the same branch may
//   follow each other with no gap (last written row is forwarded).
// Pipeline: after its sample is accepted, a result passes the row read,
//   multiply and group-sum registers, then the result queue.
// Reset: frame count and pipeline clear at once; the delay memory is then
//   zeroed one row per cycle, all BRANCHES (1024) rows, with in_ch.ready low.
//   Coefficients are not cleared and must be loaded before use.
// Stall: results wait in an 8-word queue. in_ch.ready drops, outside the
//   reset clear, only when the queue plus results still in the pipeline would
//   fill it, so the input side keeps running while out_ch is stalled for short spells.
module polyphase_fir_branch_synthesis_top (
  input  logic             clk,
  input  logic             rst_n,
  pfb_in_if.sink           in_ch,
  pfb_out_if.source        out_ch
);

  // --- accept side ---------------------------------------------------------
  logic [31:0]                 branch32, tap32;
  logic                        in_range, tap_ok, accept;
  logic                        is_sample, sample_acc, emit, emit_acc;
  logic [pfb_pkg::ADDR_W-1:0]  in_addr;
  logic [pfb_pkg::FRM_W-1:0]   frames_r;
  logic [pfb_pkg::CNT_W-1:0]   credit_r;
  logic                        mem_busy;
  logic                        out_pop;

  pfb_pkg::coef_wr_t  coef_wr;
  pfb_pkg::coef_row_t coef_rd;
  pfb_pkg::dly_row_t  dly_rd;
  pfb_pkg::dly_wr_t   dly_wr;

  assign branch32   = 32'(in_ch.branch);
  assign tap32      = 32'(in_ch.tap);
  assign in_range   = branch32 < pfb_pkg::BRANCHES;
  assign tap_ok     = tap32 < pfb_pkg::TAPS;
  assign in_addr    = branch32[pfb_pkg::ADDR_W-1:0];
  assign is_sample  = (in_ch.kind == pfb_pkg::KIND_SAMPLE);

  // ready ignores the payload: credit covers the worst case
  assign in_ch.ready = !mem_busy && (credit_r < pfb_pkg::CNT_W'(pfb_pkg::FIFO_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign sample_acc  = accept && in_range && is_sample;
  assign emit        = (frames_r == pfb_pkg::FRM_W'(pfb_pkg::TAPS - 1));
  assign emit_acc    = sample_acc && emit;
  assign out_pop     = out_ch.valid && out_ch.ready;

  // frame counter, saturating at TAPS-1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= '0;
    end else if (sample_acc && !emit &&
                 (in_addr == pfb_pkg::ADDR_W'(pfb_pkg::BRANCHES - 1))) begin
      frames_r <= frames_r + 1'b1;
    end
  end

  // words owed to the result queue: in flight plus queued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      unique case ({emit_acc, out_pop})
        2'b10:   credit_r <= credit_r + 1'b1;
        2'b01:   credit_r <= credit_r - 1'b1;
        default: credit_r <= credit_r;
      endcase
    end
  end

  // coefficient written at accept; a later sample's read sees it
  always_comb begin
    coef_wr.en   = accept && in_range && !is_sample && tap_ok;
    coef_wr.addr = in_addr;
    coef_wr.lane = tap32[pfb_pkg::TAP_W-1:0];
    coef_wr.data = in_ch.coefficient;
  end

  pfb_coef_mem u_coef_mem (
    .clk     (clk),
    .rd_addr (in_addr),
    .rd_data (coef_rd),
    .wr      (coef_wr)
  );

  pfb_delay_mem u_delay_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (in_addr),
    .rd_data (dly_rd),
    .wr      (dly_wr),
    .busy    (mem_busy)
  );

  // --- row stage: shift in the new sample, write the row back --------------
  logic                         s1_valid_r, s1_emit_r;
  logic [pfb_pkg::ADDR_W-1:0]   s1_addr_r;
  logic [pfb_pkg::BRANCH_W-1:0] s1_branch_r;
  pfb_pkg::sample_t             s1_sample_r;

  logic                         fwd_valid_r;
  logic [pfb_pkg::ADDR_W-1:0]   fwd_addr_r;
  pfb_pkg::dly_row_t            fwd_row_r;

  logic                         fwd_hit;
  pfb_pkg::dly_row_t            cur_row, new_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= sample_acc;
      fwd_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_emit_r   <= emit;
    s1_addr_r   <= in_addr;
    s1_branch_r <= in_ch.branch;
    s1_sample_r <= in_ch.sample;
    fwd_addr_r  <= s1_addr_r;
    fwd_row_r   <= new_row;
  end

  // the row written last cycle is not yet in the memory read data
  assign fwd_hit = fwd_valid_r && (fwd_addr_r == s1_addr_r);
  assign cur_row = fwd_hit ? fwd_row_r : dly_rd;

  // lane 0 holds the newest sample
  always_comb begin
    new_row[0] = s1_sample_r;
    for (int k = 1; k < pfb_pkg::TAPS; k++) begin
      new_row[k] = cur_row[k-1];
    end
  end

  always_comb begin
    dly_wr.en   = s1_valid_r;
    dly_wr.addr = s1_addr_r;
    dly_wr.data = new_row;
  end

  // --- multiply-accumulate and result queue --------------------------------
  logic          res_valid;
  pfb_pkg::res_t res, q_data;
  logic          q_valid;

  pfb_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r && s1_emit_r),
    .row       (new_row),
    .coef      (coef_rd),
    .branch    (s1_branch_r),
    .res_valid (res_valid),
    .res       (res)
  );

  pfb_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  assign out_ch.valid      = q_valid;
  assign out_ch.filtered   = q_data.filtered;
  assign out_ch.out_branch = q_data.branch;

endmodule
